// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the LED keyframe animator.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/lkfa_pkg.sv =====
// Shared types and constants of the LED keyframe animator.
// Used by lkfa_div and led_keyframe_animator_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lkfa_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_LOAD     = 2'd1,
        FUNC_RESTART  = 2'd2,
        FUNC_ACTIVATE = 2'd3
    } func_t;

    localparam logic [2:0] CFG_ANIM_MODE     = 3'd0;
    localparam logic [2:0] CFG_FRAME_COUNT   = 3'd1;
    localparam logic [2:0] CFG_LOOP_START    = 3'd2;
    localparam logic [2:0] CFG_TICK_PERIOD   = 3'd3;
    localparam logic [2:0] CFG_START_ACTIVE  = 3'd4;
    localparam logic [2:0] CFG_PHASE_STEP    = 3'd5;
    localparam logic [2:0] CFG_STAR_TOTAL    = 3'd6;
    localparam logic [2:0] CFG_ADVANCE_TICKS = 3'd7;

    localparam int TIME_W    = 13;
    localparam int FRAME_W   = 37;
    localparam int DIV_LANES = 3;
    localparam int DIV_NUM_W = 24;
    localparam int DIV_DEN_W = 13;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [20:0] {
        S_IDLE   = 21'd1,
        S_GAP    = 21'd2,
        S_GAP_W  = 21'd4,
        S_STAR   = 21'd8,
        S_LED_RD = 21'd16,
        S_O_RD   = 21'd32,
        S_D_RD   = 21'd64,
        S_EVAL   = 21'd128,
        S_PROD   = 21'd256,
        S_DIVGO  = 21'd512,
        S_DIVW   = 21'd1024,
        S_LP_RD  = 21'd2048,
        S_LP_GO  = 21'd4096,
        S_LP_W   = 21'd8192,
        S_EMIT   = 21'd16384,
        S_RS_RD  = 21'd32768,
        S_RS_GO  = 21'd65536,
        S_RS_W   = 21'd131072,
        S_RS_MUL = 21'd262144,
        S_RS_DGO = 21'd524288,
        S_RS_DW  = 21'd1048576
    } state_t;

    function automatic logic [7:0] sat8(input logic [DIV_NUM_W-1:0] v);
        return (v > DIV_NUM_W'(255)) ? 8'hFF : v[7:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lkfa_div.sv =====
// Restoring divider, one quotient bit per cycle, three lanes on one divisor.
// Depends on lkfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lkfa_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lkfa_pkg::DIV_NUM_W-1:0] num [lkfa_pkg::DIV_LANES],
    input  logic [lkfa_pkg::DIV_DEN_W-1:0] den,
    output logic [lkfa_pkg::DIV_NUM_W-1:0] quo [lkfa_pkg::DIV_LANES],
    output logic [lkfa_pkg::DIV_DEN_W-1:0] rem,
    output lkfa_pkg::div_stat_t            stat
);

    localparam int CNT_W = $clog2(lkfa_pkg::DIV_NUM_W);

    logic [lkfa_pkg::DIV_NUM_W-1:0] quo_reg [lkfa_pkg::DIV_LANES];
    logic [lkfa_pkg::DIV_DEN_W-1:0] rem_reg [lkfa_pkg::DIV_LANES];
    logic [lkfa_pkg::DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [lkfa_pkg::DIV_DEN_W:0]   trial [lkfa_pkg::DIV_LANES];

    always_comb
    begin
        for (int l = 0; l < lkfa_pkg::DIV_LANES; l++)
        begin
            trial[l] = {rem_reg[l], quo_reg[l][lkfa_pkg::DIV_NUM_W-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(lkfa_pkg::DIV_NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            for (int l = 0; l < lkfa_pkg::DIV_LANES; l++)
            begin
                quo_reg[l] <= num[l];
                rem_reg[l] <= '0;
            end
        end
        else if (busy_reg)
        begin
            for (int l = 0; l < lkfa_pkg::DIV_LANES; l++)
            begin
                if (trial[l] >= {1'b0, den_reg})
                begin
                    rem_reg[l] <= lkfa_pkg::DIV_DEN_W'(trial[l] - {1'b0, den_reg});
                    quo_reg[l] <= {quo_reg[l][lkfa_pkg::DIV_NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[l] <= trial[l][lkfa_pkg::DIV_DEN_W-1:0];
                    quo_reg[l] <= {quo_reg[l][lkfa_pkg::DIV_NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign quo       = quo_reg;
    assign rem       = rem_reg[0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/led_keyframe_animator_top.sv =====
// LED keyframe animator: per-LED keyframe color interpolation with shooting-star mode.
// Depends on lkfa_pkg, lkfa_div and assert_macros.svh.
//
// Load and activate beats are taken in the idle state. A tick beat yields LED_COUNT
// color beats, LED 0 first, tlast on the last one. Each LED walks a sequencer over two
// registered-read memories (LED state and keyframe table); an inactive, held or finished
// LED skips the shared divider, and one that interpolates or loops back waits on it; a
// stalled output adds its stall. Shooting-star restarts add one divide for the star gap
// and one step per star to a tick. A restart beat runs one divide for the restart
// modulus, then a divide per LED that is skipped when the modulus is zero. A new beat is
// taken once the last color of the previous one sits in the output register.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module led_keyframe_animator_top #(
    parameter int LED_COUNT   = 16,
    parameter int FRAME_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_tvalid,
    output logic        in_tready,
    input  logic [63:0] in_tdata,   // frame_slot, frame_red, frame_green, frame_blue,
                                    // frame_time, enable_bits
    input  logic [1:0]  in_tuser,   // func
    output logic        out_tvalid,
    input  logic        out_tready,
    output logic [31:0] out_tdata,  // led_number, out_red, out_green, out_blue
    output logic        out_tlast
);

    localparam int LED_W  = $clog2(LED_COUNT);
    localparam int FW     = $clog2(FRAME_DEPTH);
    localparam int LEDM_W = 2 * FW + 8;
    localparam int NW     = lkfa_pkg::DIV_NUM_W;
    localparam int DW     = lkfa_pkg::DIV_DEN_W;
    localparam int LANES  = lkfa_pkg::DIV_LANES;

    // configuration
    logic        anim_mode_reg;
    logic [4:0]  frame_count_reg;
    logic [3:0]  loop_start_reg;
    logic [7:0]  tick_period_reg;
    logic [15:0] start_active_reg;
    logic [7:0]  phase_step_reg;
    logic [4:0]  star_total_reg;
    logic [15:0] advance_ticks_reg;

    lkfa_pkg::state_t state_reg, state_next;

    logic [LED_COUNT-1:0] active_reg;
    logic [LED_W-1:0]     star_pos_reg;
    logic [15:0]          hold_reg;
    logic [LED_W-1:0]     idx_reg;
    logic [LED_W:0]       gap_reg;
    logic [LED_W-1:0]     star_p_reg;
    logic [4:0]           star_k_reg;

    logic [FW-1:0]        os_reg, ds_reg, no_reg, nd_reg;
    logic [7:0]           e_reg;
    logic [15:0]          t_reg;
    logic [lkfa_pkg::FRAME_W-1:0] o_reg;
    logic [7:0]           dcol_reg [LANES];
    logic [7:0]           col_reg  [LANES];
    logic signed [17:0]   num_s_reg;
    logic signed [13:0]   den_s_reg;
    logic signed [26:0]   prod_reg [LANES];
    logic                 neg_reg  [LANES];
    logic [DW-1:0]        mod_reg;
    logic [LED_W+7:0]     rsprod_reg;

    logic                 out_valid_reg;
    logic [7:0]           out_col_reg [LANES];
    logic [LED_W-1:0]     out_led_reg;
    logic                 out_last_reg;

    // memories
    logic [lkfa_pkg::FRAME_W-1:0] frame_mem [FRAME_DEPTH];
    logic [lkfa_pkg::FRAME_W-1:0] frame_rdata_reg;
    logic [FW-1:0]                frame_raddr;
    logic [LEDM_W-1:0]            led_mem [LED_COUNT];
    logic [LEDM_W-1:0]            led_rdata_reg;
    logic                         led_rvalid_reg;
    logic [LED_COUNT-1:0]         led_valid_reg;
    logic                         led_we;
    logic [LED_W-1:0]             led_waddr;
    logic [LEDM_W-1:0]            led_wdata;

    // divider
    logic                 div_start;
    logic [NW-1:0]        div_num [LANES];
    logic [DW-1:0]        div_den;
    logic [NW-1:0]        div_quo [LANES];
    logic [DW-1:0]        div_rem;
    lkfa_pkg::div_stat_t  div_stat;

    // decoded fields and helpers
    lkfa_pkg::func_t      in_func;
    logic                 in_beat;
    logic [7:0]           per_eff;
    logic [8:0]           cnt_eff;
    logic [FW-1:0]        ls_mod, slot_mod, last_slot;
    logic [LEDM_W-1:0]    led_q;
    logic [FW-1:0]        lq_os, lq_ds;
    logic [7:0]           lq_e;
    logic [7:0]           fr_col [LANES];
    logic [7:0]           oc     [LANES];
    logic [12:0]          fr_t, o_t;
    logic                 ev_hit, ev_eq, ev_wrap, ev_act;
    logic [8:0]           nd1;
    logic [FW-1:0]        ev_no, ev_nd;
    logic [7:0]           e_new;
    logic                 led_last;
    logic [LED_W:0]       psum;
    logic [LED_W-1:0]     pos_inc;
    logic                 emit_load;

    function automatic logic [FW-1:0] frame_mod(input logic [3:0] v);
        logic [8:0] r;
        r = 9'(v);
        for (int k = 0; k < 8; k++)
        begin
            if (int'(r) >= FRAME_DEPTH)
            begin
                r = r - 9'(FRAME_DEPTH);
            end
        end
        return r[FW-1:0];
    endfunction

    assign in_func   = lkfa_pkg::func_t'(in_tuser);
    assign in_tready = (state_reg == lkfa_pkg::S_IDLE);
    assign in_beat   = in_tvalid && in_tready;
    assign per_eff   = (tick_period_reg == 8'd0) ? 8'd1 : tick_period_reg;
    assign ls_mod    = frame_mod(loop_start_reg);
    assign slot_mod  = frame_mod(in_tdata[3:0]);
    assign last_slot = FW'(cnt_eff - 9'd1);
    assign led_last  = (idx_reg == LED_W'(LED_COUNT - 1));
    assign emit_load = !out_valid_reg || out_tready;

    always_comb
    begin
        if (frame_count_reg == 5'd0)
        begin
            cnt_eff = 9'd1;
        end
        else if (int'(frame_count_reg) > FRAME_DEPTH)
        begin
            cnt_eff = 9'(FRAME_DEPTH);
        end
        else
        begin
            cnt_eff = 9'(frame_count_reg);
        end
    end

    assign led_q = led_rvalid_reg ? led_rdata_reg : '0;
    assign lq_os = led_q[LEDM_W-1 -: FW];
    assign lq_ds = led_q[8 +: FW];
    assign lq_e  = led_q[7:0];

    assign fr_col[0] = frame_rdata_reg[7:0];
    assign fr_col[1] = frame_rdata_reg[15:8];
    assign fr_col[2] = frame_rdata_reg[23:16];
    assign fr_t      = frame_rdata_reg[36:24];
    assign oc[0]     = o_reg[7:0];
    assign oc[1]     = o_reg[15:8];
    assign oc[2]     = o_reg[23:16];
    assign o_t       = o_reg[36:24];

    assign ev_act  = active_reg[idx_reg];
    assign ev_hit  = t_reg >= 16'(fr_t);
    assign ev_eq   = (fr_t == o_t);
    assign nd1     = 9'(ds_reg) + 9'd1;
    assign ev_wrap = nd1 >= cnt_eff;
    assign ev_no   = ev_wrap ? ls_mod : ds_reg;
    assign ev_nd   = !ev_wrap ? FW'(nd1) :
                     ((9'(ls_mod) + 9'd1 < cnt_eff - 9'd1) ? FW'(9'(ls_mod) + 9'd1)
                                                          : last_slot);
    assign e_new   = (e_reg == 8'hFF) ? e_reg : e_reg + 8'd1;

    assign psum    = (LED_W + 1)'(star_p_reg) + gap_reg;
    assign pos_inc = (star_pos_reg == LED_W'(LED_COUNT - 1)) ? '0 : star_pos_reg + 1'b1;

    always_comb
    begin
        case (state_reg)
            lkfa_pkg::S_O_RD:  frame_raddr = lq_os;
            lkfa_pkg::S_D_RD:  frame_raddr = ds_reg;
            lkfa_pkg::S_LP_RD: frame_raddr = no_reg;
            lkfa_pkg::S_RS_RD: frame_raddr = last_slot;
            default:           frame_raddr = os_reg;
        endcase
    end

    // LED state write port
    always_comb
    begin
        led_we    = 1'b0;
        led_waddr = idx_reg;
        led_wdata = '0;
        case (state_reg)
            lkfa_pkg::S_STAR:
            begin
                led_we    = 1'b1;
                led_waddr = star_p_reg;
            end
            lkfa_pkg::S_EVAL:
            begin
                led_we    = ev_act && !(ev_hit && ev_wrap);
                led_wdata = ev_hit ? {ev_no, ev_nd, e_new} : {os_reg, ds_reg, e_new};
            end
            lkfa_pkg::S_LP_W:
            begin
                led_we    = div_stat.done;
                led_wdata = {no_reg, nd_reg, lkfa_pkg::sat8(div_quo[0])};
            end
            lkfa_pkg::S_RS_MUL:
            begin
                led_we = (mod_reg == '0);
            end
            lkfa_pkg::S_RS_DW:
            begin
                led_we    = div_stat.done;
                led_wdata = {{(2 * FW){1'b0}}, lkfa_pkg::sat8(NW'(div_rem))};
            end
            default:
            begin
                led_we = 1'b0;
            end
        endcase
    end

    // divider operands
    always_comb
    begin
        div_start = 1'b0;
        div_den   = DW'(per_eff);
        for (int l = 0; l < LANES; l++)
        begin
            div_num[l] = '0;
        end
        case (state_reg)
            lkfa_pkg::S_GAP:
            begin
                div_start  = 1'b1;
                div_num[0] = NW'(LED_COUNT);
                div_den    = DW'(star_total_reg);
            end
            lkfa_pkg::S_DIVGO:
            begin
                div_start = 1'b1;
                for (int l = 0; l < LANES; l++)
                begin
                    div_num[l] = prod_reg[l][26] ? NW'(-prod_reg[l]) : NW'(prod_reg[l]);
                end
                div_den = den_s_reg[13] ? DW'(-den_s_reg) : DW'(den_s_reg);
            end
            lkfa_pkg::S_LP_GO:
            begin
                div_start  = 1'b1;
                div_num[0] = NW'(fr_t) + NW'(per_eff) - NW'(1);
            end
            lkfa_pkg::S_RS_GO:
            begin
                div_start  = 1'b1;
                div_num[0] = NW'(fr_t);
            end
            lkfa_pkg::S_RS_DGO:
            begin
                div_start  = 1'b1;
                div_num[0] = NW'(rsprod_reg);
                div_den    = mod_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    lkfa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .rem   (div_rem),
        .stat  (div_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lkfa_pkg::S_IDLE:
            begin
                if (in_beat && in_func == lkfa_pkg::FUNC_RESTART)
                begin
                    state_next = lkfa_pkg::S_RS_RD;
                end
                else if (in_beat && in_func == lkfa_pkg::FUNC_TICK)
                begin
                    if (anim_mode_reg && hold_reg == advance_ticks_reg &&
                        star_total_reg != 5'd0)
                    begin
                        state_next = lkfa_pkg::S_GAP;
                    end
                    else
                    begin
                        state_next = lkfa_pkg::S_LED_RD;
                    end
                end
            end
            lkfa_pkg::S_GAP:   state_next = lkfa_pkg::S_GAP_W;
            lkfa_pkg::S_GAP_W: if (div_stat.done) state_next = lkfa_pkg::S_STAR;
            lkfa_pkg::S_STAR:
            begin
                if (star_k_reg == star_total_reg - 5'd1)
                begin
                    state_next = lkfa_pkg::S_LED_RD;
                end
            end
            lkfa_pkg::S_LED_RD: state_next = lkfa_pkg::S_O_RD;
            lkfa_pkg::S_O_RD:   state_next = lkfa_pkg::S_D_RD;
            lkfa_pkg::S_D_RD:   state_next = lkfa_pkg::S_EVAL;
            lkfa_pkg::S_EVAL:
            begin
                if (!ev_act || ev_eq || ev_hit)
                begin
                    state_next = (ev_act && ev_hit && ev_wrap) ? lkfa_pkg::S_LP_RD
                                                                : lkfa_pkg::S_EMIT;
                end
                else
                begin
                    state_next = lkfa_pkg::S_PROD;
                end
            end
            lkfa_pkg::S_PROD:  state_next = lkfa_pkg::S_DIVGO;
            lkfa_pkg::S_DIVGO: state_next = lkfa_pkg::S_DIVW;
            lkfa_pkg::S_DIVW:  if (div_stat.done) state_next = lkfa_pkg::S_EMIT;
            lkfa_pkg::S_LP_RD: state_next = lkfa_pkg::S_LP_GO;
            lkfa_pkg::S_LP_GO: state_next = lkfa_pkg::S_LP_W;
            lkfa_pkg::S_LP_W:  if (div_stat.done) state_next = lkfa_pkg::S_EMIT;
            lkfa_pkg::S_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = led_last ? lkfa_pkg::S_IDLE : lkfa_pkg::S_LED_RD;
                end
            end
            lkfa_pkg::S_RS_RD: state_next = lkfa_pkg::S_RS_GO;
            lkfa_pkg::S_RS_GO: state_next = lkfa_pkg::S_RS_W;
            lkfa_pkg::S_RS_W:  if (div_stat.done) state_next = lkfa_pkg::S_RS_MUL;
            lkfa_pkg::S_RS_MUL:
            begin
                if (mod_reg != '0)
                begin
                    state_next = lkfa_pkg::S_RS_DGO;
                end
                else if (led_last)
                begin
                    state_next = lkfa_pkg::S_IDLE;
                end
            end
            lkfa_pkg::S_RS_DGO: state_next = lkfa_pkg::S_RS_DW;
            lkfa_pkg::S_RS_DW:
            begin
                if (div_stat.done)
                begin
                    state_next = led_last ? lkfa_pkg::S_IDLE : lkfa_pkg::S_RS_MUL;
                end
            end
            default: state_next = lkfa_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= lkfa_pkg::S_IDLE;
            anim_mode_reg     <= 1'b0;
            frame_count_reg   <= 5'd1;
            loop_start_reg    <= 4'd0;
            tick_period_reg   <= 8'd40;
            start_active_reg  <= 16'd0;
            phase_step_reg    <= 8'd0;
            star_total_reg    <= 5'd1;
            advance_ticks_reg <= 16'd0;
            active_reg        <= '0;
            star_pos_reg      <= '0;
            hold_reg          <= '0;
            idx_reg           <= '0;
            star_k_reg        <= '0;
            led_valid_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    lkfa_pkg::CFG_ANIM_MODE:     anim_mode_reg     <= cfg_data[0];
                    lkfa_pkg::CFG_FRAME_COUNT:   frame_count_reg   <= cfg_data[4:0];
                    lkfa_pkg::CFG_LOOP_START:    loop_start_reg    <= cfg_data[3:0];
                    lkfa_pkg::CFG_TICK_PERIOD:   tick_period_reg   <= cfg_data[7:0];
                    lkfa_pkg::CFG_START_ACTIVE:  start_active_reg  <= cfg_data;
                    lkfa_pkg::CFG_PHASE_STEP:    phase_step_reg    <= cfg_data[7:0];
                    lkfa_pkg::CFG_STAR_TOTAL:    star_total_reg    <= cfg_data[4:0];
                    lkfa_pkg::CFG_ADVANCE_TICKS: advance_ticks_reg <= cfg_data;
                    default:                     anim_mode_reg     <= anim_mode_reg;
                endcase
            end

            if (led_we)
            begin
                led_valid_reg[led_waddr] <= 1'b1;
            end

            if (state_reg == lkfa_pkg::S_EMIT && emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                lkfa_pkg::S_IDLE:
                begin
                    idx_reg <= '0;
                    if (in_beat)
                    begin
                        case (in_func)
                            lkfa_pkg::FUNC_ACTIVATE:
                                active_reg <= active_reg | LED_COUNT'(in_tdata[56:41]);
                            lkfa_pkg::FUNC_RESTART:
                            begin
                                active_reg   <= LED_COUNT'(start_active_reg);
                                star_pos_reg <= '0;
                                hold_reg     <= '0;
                            end
                            lkfa_pkg::FUNC_TICK:
                            begin
                                if (anim_mode_reg)
                                begin
                                    if (hold_reg == advance_ticks_reg)
                                    begin
                                        hold_reg     <= 16'd1;
                                        star_pos_reg <= pos_inc;
                                    end
                                    else
                                    begin
                                        hold_reg <= hold_reg + 16'd1;
                                    end
                                end
                            end
                            default: hold_reg <= hold_reg;
                        endcase
                    end
                end
                lkfa_pkg::S_GAP_W:
                begin
                    star_k_reg <= '0;
                end
                lkfa_pkg::S_STAR:
                begin
                    active_reg[star_p_reg] <= 1'b1;
                    star_k_reg             <= star_k_reg + 5'd1;
                end
                lkfa_pkg::S_EMIT:
                begin
                    if (emit_load)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                lkfa_pkg::S_RS_MUL:
                begin
                    if (mod_reg == '0)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                lkfa_pkg::S_RS_DW:
                begin
                    if (div_stat.done)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default: idx_reg <= idx_reg;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lkfa_pkg::S_GAP_W:
            begin
                gap_reg    <= (LED_W + 1)'(div_quo[0]);
                star_p_reg <= star_pos_reg;
            end
            lkfa_pkg::S_STAR:
            begin
                star_p_reg <= (psum >= (LED_W + 1)'(LED_COUNT))
                              ? LED_W'(psum - (LED_W + 1)'(LED_COUNT)) : LED_W'(psum);
            end
            lkfa_pkg::S_O_RD:
            begin
                os_reg <= lq_os;
                ds_reg <= lq_ds;
                e_reg  <= lq_e;
                t_reg  <= 16'(lq_e * per_eff);
            end
            lkfa_pkg::S_D_RD:
            begin
                o_reg <= frame_rdata_reg;
            end
            lkfa_pkg::S_EVAL:
            begin
                no_reg    <= ev_no;
                nd_reg    <= ev_nd;
                num_s_reg <= $signed(18'(t_reg)) - $signed(18'(o_t));
                den_s_reg <= $signed(14'(fr_t)) - $signed(14'(o_t));
                for (int l = 0; l < LANES; l++)
                begin
                    dcol_reg[l] <= fr_col[l];
                    col_reg[l]  <= (ev_act && ev_hit) ? fr_col[l] : oc[l];
                end
            end
            lkfa_pkg::S_PROD:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    prod_reg[l] <= ($signed({1'b0, dcol_reg[l]}) - $signed({1'b0, oc[l]}))
                                   * num_s_reg;
                end
            end
            lkfa_pkg::S_DIVGO:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    neg_reg[l] <= prod_reg[l][26] ^ den_s_reg[13];
                end
            end
            lkfa_pkg::S_DIVW:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    col_reg[l] <= neg_reg[l] ? oc[l] - div_quo[l][7:0]
                                             : oc[l] + div_quo[l][7:0];
                end
            end
            lkfa_pkg::S_EMIT:
            begin
                if (emit_load)
                begin
                    out_col_reg  <= col_reg;
                    out_led_reg  <= idx_reg;
                    out_last_reg <= led_last;
                end
            end
            lkfa_pkg::S_RS_W:
            begin
                mod_reg <= div_quo[0][DW-1:0];
            end
            lkfa_pkg::S_RS_MUL:
            begin
                rsprod_reg <= (LED_W + 8)'(idx_reg * phase_step_reg);
            end
            default:
            begin
                mod_reg <= mod_reg;
            end
        endcase
    end

    // keyframe table
    always_ff @(posedge clk)
    begin
        if (in_beat && in_func == lkfa_pkg::FUNC_LOAD)
        begin
            frame_mem[slot_mod] <= {in_tdata[40:28], in_tdata[27:20], in_tdata[19:12],
                                    in_tdata[11:4]};
        end
        frame_rdata_reg <= frame_mem[frame_raddr];
    end

    // per-LED origin, target and tick counter
    always_ff @(posedge clk)
    begin
        if (led_we)
        begin
            led_mem[led_waddr] <= led_wdata;
        end
        led_rdata_reg  <= led_mem[idx_reg];
        led_rvalid_reg <= led_valid_reg[idx_reg];
    end

    assign out_tvalid = out_valid_reg;
    assign out_tlast  = out_last_reg;
    assign out_tdata  = {4'd0, out_col_reg[2], out_col_reg[1], out_col_reg[0],
                         4'(out_led_reg)};

    `ASSERT_IMPLY(a_div_free, clk, rst_n, div_start, !div_stat.busy)
    `ASSERT_NEXT(a_tick_holds_in, clk, rst_n,
                 in_beat && in_func == lkfa_pkg::FUNC_TICK, !in_tready)
    `ASSERT_IMPLY(a_last_led, clk, rst_n, out_tvalid && out_tlast,
                  out_tdata[3:0] == 4'(LED_COUNT - 1))
    `ASSERT_IMPLY(a_div_wait, clk, rst_n, div_stat.done,
                  state_reg == lkfa_pkg::S_GAP_W || state_reg == lkfa_pkg::S_DIVW ||
                  state_reg == lkfa_pkg::S_LP_W || state_reg == lkfa_pkg::S_RS_W ||
                  state_reg == lkfa_pkg::S_RS_DW)

endmodule

`default_nettype wire
